// ===== sv/ppsm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsm_pkg
// shared types and constants of the pulse period speed meter
// ----------------------------------------------------------------------------
`default_nettype none

package ppsm_pkg;

   // event codes carried on the result channel
   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_STALL  = 3'd1;
   localparam logic [2:0] KIND_GLITCH = 3'd2;
   localparam logic [2:0] KIND_ACCUM  = 3'd3;
   localparam logic [2:0] KIND_SPEED  = 3'd4;

   // input command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_EDGE = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_SPEED_CONSTANT     = 2'd0;
   localparam logic [1:0] CSR_STALL_LIMIT        = 2'd1;
   localparam logic [1:0] CSR_PULSES_PER_READING = 2'd2;
   localparam logic [1:0] CSR_GLITCH_MINIMUM     = 2'd3;

   // reset values
   localparam logic [31:0] SPEED_CONSTANT_RESET     = 32'd600000000;
   localparam logic [15:0] STALL_LIMIT_RESET        = 16'd100;
   localparam logic [7:0]  PULSES_PER_READING_RESET = 8'd2;
   localparam logic [15:0] GLITCH_MINIMUM_RESET     = 16'd200;
   localparam logic [31:0] PERIOD_SUM_RESET         = 32'd65536;

   localparam logic [15:0] STALL_TICKS_TOP = 16'hFFFF;

   // classified item between front and back
   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] period;
   } entry_type;

endpackage

`default_nettype wire

// ===== sv/ppsm_front.sv =====
// ----------------------------------------------------------------------------
// ppsm_front
// keeps the stall counter and classifies each item as tick, stall reset,
// glitch or accumulate candidate
// ----------------------------------------------------------------------------
`default_nettype none

module ppsm_front import ppsm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [15:0] req_period_count,
   input  wire logic [15:0] stall_limit,
   input  wire logic [15:0] glitch_minimum,
   output logic             push_valid,
   input  wire logic        push_ready,
   output entry_type        push_data
);

   logic [15:0] stall_ticks_ff;
   logic [15:0] stall_ticks_in;
   logic        take;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign take       = req_valid && push_ready;

   always_comb begin
      push_data.period = req_period_count;
      stall_ticks_in   = stall_ticks_ff;
      priority if (req_command == CMD_TICK) begin
         push_data.kind = KIND_TICK;
         if (stall_ticks_ff != STALL_TICKS_TOP) begin
            stall_ticks_in = stall_ticks_ff + 16'd1;
         end
      end else if (stall_ticks_ff >= stall_limit) begin
         push_data.kind = KIND_STALL;
         stall_ticks_in = '0;
      end else if (req_period_count < glitch_minimum) begin
         push_data.kind = KIND_GLITCH;
         stall_ticks_in = '0;
      end else begin
         push_data.kind = KIND_ACCUM;
         stall_ticks_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stall_ticks_ff <= '0;
      end else if (take) begin
         stall_ticks_ff <= stall_ticks_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ppsm_queue.sv =====
// ----------------------------------------------------------------------------
// ppsm_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module ppsm_queue import ppsm_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire entry_type push_data,
   output logic           pop_valid,
   input  wire logic      pop_ready,
   output entry_type      pop_data
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== sv/ppsm_divider.sv =====
// ----------------------------------------------------------------------------
// ppsm_divider
// restoring radix-2 divider, one quotient bit per cycle, 32 steps
// ----------------------------------------------------------------------------
`default_nettype none

module ppsm_divider import ppsm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] numerator,
   input  wire logic [31:0] denominator,
   output logic             done,
   output logic [15:0]      quotient
);

   logic        run_ff;
   logic        done_ff;
   logic [4:0]  count_ff;
   logic [31:0] rem_ff;
   logic [31:0] quot_ff;
   logic [31:0] den_ff;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        fits;

   // a zero denominator always fits, which gives all ones
   assign shifted  = {rem_ff, quot_ff[31]};
   assign diff     = shifted - {1'b0, den_ff};
   assign fits     = (shifted >= {1'b0, den_ff});
   assign done     = done_ff;
   assign quotient = quot_ff[15:0];

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quot_ff <= numerator;
         den_ff  <= denominator;
      end else if (run_ff) begin
         rem_ff  <= fits ? diff[31:0] : shifted[31:0];
         quot_ff <= {quot_ff[30:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff   <= 1'b1;
            count_ff <= 5'd31;
         end else if (run_ff) begin
            count_ff <= count_ff - 5'd1;
            if (count_ff == 5'd0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/ppsm_back.sv =====
// ----------------------------------------------------------------------------
// ppsm_back
// accumulates periods, counts pulses, runs the divider and drives results
// ----------------------------------------------------------------------------
`default_nettype none

module ppsm_back import ppsm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] speed_constant,
   input  wire logic [7:0]  pulses_per_reading,
   input  wire logic        pop_valid,
   output logic             pop_ready,
   input  wire entry_type   pop_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_speed,
   output logic [2:0]       rsp_event_kind
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]  state_ff;
   logic [1:0]  state_in;
   logic [31:0] sum_ff;
   logic [31:0] sum_in;
   logic [7:0]  step_ff;
   logic [7:0]  step_in;
   logic [15:0] speed_ff;
   logic [15:0] speed_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_speed_ff;
   logic [15:0] rsp_speed_in;
   logic [2:0]  rsp_kind_ff;
   logic [2:0]  rsp_kind_in;
   logic        out_free;
   logic        take;
   logic [31:0] sum_add;
   logic [7:0]  step_add;
   logic        div_start;
   logic        div_done;
   logic [15:0] div_quotient;

   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign pop_ready      = (state_ff == ST_IDLE) && out_free;
   assign take           = pop_valid && pop_ready;
   assign sum_add        = sum_ff + {16'd0, pop_data.period};
   assign step_add       = step_ff + 8'd1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_speed      = rsp_speed_ff;
   assign rsp_event_kind = rsp_kind_ff;

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      step_in      = step_ff;
      speed_in     = speed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_speed_in = rsp_speed_ff;
      rsp_kind_in  = rsp_kind_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               rsp_speed_in = speed_ff;
               rsp_kind_in  = pop_data.kind;
               rsp_valid_in = 1'b1;
               unique case (pop_data.kind)
                  KIND_STALL: begin
                     sum_in  = '0;
                     step_in = '0;
                  end
                  KIND_ACCUM: begin
                     if (step_add == pulses_per_reading) begin
                        // reading due: result waits for the quotient
                        sum_in       = '0;
                        step_in      = '0;
                        div_start    = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_DIV;
                     end else begin
                        sum_in  = sum_add;
                        step_in = step_add;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               speed_in = div_quotient;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = speed_ff;
               rsp_kind_in  = KIND_SPEED;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   ppsm_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (speed_constant),
      .denominator (sum_add),
      .done        (div_done),
      .quotient    (div_quotient)
   );

   always_ff @(posedge clock) begin
      rsp_speed_ff <= rsp_speed_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= PERIOD_SUM_RESET;
         step_ff      <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         step_ff      <= step_in;
         speed_ff     <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/pulse_period_speed_meter.sv =====
// ----------------------------------------------------------------------------
// pulse_period_speed_meter
// period-based tachometer: stall counter, glitch filter, period
// accumulator and speed division
//
//   channel  ports                                   handshake
//   req      req_command, req_period_count           req_valid / req_ready
//   rsp      rsp_speed, rsp_event_kind               rsp_valid / rsp_ready
//   csr      csr_index, csr_wr_data                  csr_wr_en, no wait
//
// ticks, glitches, stall resets and plain accumulates give their result in the
// cycle after the back takes them from the queue; a pulse that completes a
// reading gives its speed after the 32-step radix-2 divider, when rsp is free.
// the front keeps classifying into a two-entry queue while the back divides
// or waits on rsp_ready. reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_period_speed_meter import ppsm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [15:0] req_period_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_speed,
   output logic [2:0]       rsp_event_kind,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);

   logic [31:0] speed_constant_ff;
   logic [15:0] stall_limit_ff;
   logic [7:0]  pulses_per_reading_ff;
   logic [15:0] glitch_minimum_ff;

   logic        push_valid;
   logic        push_ready;
   entry_type   push_data;
   logic        pop_valid;
   logic        pop_ready;
   entry_type   pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_constant_ff     <= SPEED_CONSTANT_RESET;
         stall_limit_ff        <= STALL_LIMIT_RESET;
         pulses_per_reading_ff <= PULSES_PER_READING_RESET;
         glitch_minimum_ff     <= GLITCH_MINIMUM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SPEED_CONSTANT:     speed_constant_ff     <= csr_wr_data;
            CSR_STALL_LIMIT:        stall_limit_ff        <= csr_wr_data[15:0];
            CSR_PULSES_PER_READING: pulses_per_reading_ff <= csr_wr_data[7:0];
            CSR_GLITCH_MINIMUM:     glitch_minimum_ff     <= csr_wr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   ppsm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_period_count (req_period_count),
      .stall_limit      (stall_limit_ff),
      .glitch_minimum   (glitch_minimum_ff),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   ppsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ppsm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .speed_constant     (speed_constant_ff),
      .pulses_per_reading (pulses_per_reading_ff),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_data           (pop_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_speed          (rsp_speed),
      .rsp_event_kind     (rsp_event_kind)
   );

endmodule

`default_nettype wire
